// ===== rtl/core/ffba_pkg.sv =====
// Shared types, constants and codes for the first-fit block allocator.
`default_nettype none
package ffba_pkg;

  localparam int unsigned HEAP_SIZE   = 65536;
  localparam int unsigned GRAN_BYTES  = 16;
  localparam int unsigned NUM_GRAN    = HEAP_SIZE / GRAN_BYTES;
  localparam int unsigned IDX_W       = $clog2(NUM_GRAN);
  localparam int unsigned GRAN_SHIFT  = $clog2(GRAN_BYTES);
  localparam int unsigned SIZE_W      = IDX_W + 1;

  // Field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned REQ_W    = 17;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned BYTES_W  = 17;
  localparam int unsigned NEED_W   = REQ_W + 1 - GRAN_SHIFT;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STATS = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd2;

  // One block header, one per granule
  typedef struct packed {
    logic             valid;
    logic             free;
    logic             nx_ok;
    logic [IDX_W-1:0] nx;
    logic             pv_ok;
    logic [IDX_W-1:0] pv;
  } hdr_t;

  localparam int unsigned HDR_W = $bits(hdr_t);

  localparam hdr_t HDR_ZERO = '0;
  localparam hdr_t HDR_INIT = '{valid: 1'b1, free: 1'b1, nx_ok: 1'b0, nx: '0,
                                pv_ok: 1'b0, pv: '0};

  // Header RAM request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    hdr_t             wdata;
  } ram_req_t;

  // One result transaction
  typedef struct packed {
    logic [OFF_W-1:0]    data_offset;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    total_blocks;
    logic [CNT_W-1:0]    free_blocks;
    logic [BYTES_W-1:0]  used_bytes;
    logic [BYTES_W-1:0]  free_bytes;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/ffba_if.sv =====
// Request and result channel interfaces of the block allocator.
`default_nettype none
interface ffba_in_if;
  logic                           valid;
  logic                           ready;
  logic [ffba_pkg::FUNC_W-1:0]    func;
  logic [ffba_pkg::REQ_W-1:0]     request_bytes;
  logic [ffba_pkg::OFF_W-1:0]     block_offset;

  modport source (output valid, func, request_bytes, block_offset, input ready);
  modport sink   (input valid, func, request_bytes, block_offset, output ready);
endinterface

interface ffba_out_if;
  logic                           valid;
  logic                           ready;
  logic [ffba_pkg::OFF_W-1:0]     data_offset;
  logic [ffba_pkg::STATUS_W-1:0]  status;
  logic [ffba_pkg::CNT_W-1:0]     total_blocks;
  logic [ffba_pkg::CNT_W-1:0]     free_blocks;
  logic [ffba_pkg::BYTES_W-1:0]   used_bytes;
  logic [ffba_pkg::BYTES_W-1:0]   free_bytes;

  modport source (output valid, data_offset, status, total_blocks, free_blocks,
                  used_bytes, free_bytes, input ready);
  modport sink   (input valid, data_offset, status, total_blocks, free_blocks,
                  used_bytes, free_bytes, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ffba_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/ffba_ctrl.sv =====
// Sequencer and shared size/compare datapath walking the header chain.
`default_nettype none
module ffba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  ffba_in_if.sink                 in_ch,
  output ffba_pkg::ram_req_t      ram_req,
  input  wire ffba_pkg::hdr_t     ram_rdata,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output ffba_pkg::res_t          res
);

  typedef enum logic [24:0] {
    S_CLR    = 25'd1 << 0,
    S_IDLE   = 25'd1 << 1,
    S_DONE   = 25'd1 << 2,
    S_A_RD   = 25'd1 << 3,
    S_A_CHK  = 25'd1 << 4,
    S_A_WN   = 25'd1 << 5,
    S_A_PRD  = 25'd1 << 6,
    S_A_PWR  = 25'd1 << 7,
    S_A_WG   = 25'd1 << 8,
    S_F_RD   = 25'd1 << 9,
    S_F_CHK  = 25'd1 << 10,
    S_F_NRD  = 25'd1 << 11,
    S_F_NCHK = 25'd1 << 12,
    S_F_NCLR = 25'd1 << 13,
    S_F_NPRD = 25'd1 << 14,
    S_F_NPWR = 25'd1 << 15,
    S_F_PV   = 25'd1 << 16,
    S_F_LRD  = 25'd1 << 17,
    S_F_LCHK = 25'd1 << 18,
    S_F_GCLR = 25'd1 << 19,
    S_F_LPRD = 25'd1 << 20,
    S_F_LPWR = 25'd1 << 21,
    S_F_LWR  = 25'd1 << 22,
    S_F_WG   = 25'd1 << 23,
    S_S_RD   = 25'd1 << 24
  } state_t;

  localparam int unsigned IDX_W  = ffba_pkg::IDX_W;
  localparam int unsigned SIZE_W = ffba_pkg::SIZE_W;

  state_t                          state_r, state_nxt;
  logic [IDX_W-1:0]                g_r, g_nxt;
  logic [IDX_W-1:0]                n_r, n_nxt;
  logic [IDX_W-1:0]                clr_r, clr_nxt;
  ffba_pkg::hdr_t                  cur_r, cur_nxt;
  ffba_pkg::hdr_t                  aux_r, aux_nxt;
  logic [ffba_pkg::NEED_W-1:0]     need_r, need_nxt;
  logic                            split_r, split_nxt;
  ffba_pkg::res_t                  res_r, res_nxt;

  // Shared unit: data granules of the block just read, and its fit test
  logic [SIZE_W-1:0]               blk_end;
  logic [SIZE_W-1:0]               blk_size;
  logic                            fits;
  logic [ffba_pkg::REQ_W:0]        req_round;

  assign blk_end  = ram_rdata.nx_ok ? {1'b0, ram_rdata.nx} : SIZE_W'(ffba_pkg::NUM_GRAN);
  assign blk_size = blk_end - {1'b0, g_r} - SIZE_W'(1);
  assign fits     = ram_rdata.free && ({1'b0, need_r} <= (ffba_pkg::NEED_W + 1)'(blk_size));
  assign req_round = {1'b0, in_ch.request_bytes} + (ffba_pkg::REQ_W + 1)'(ffba_pkg::GRAN_BYTES - 1);

  assign in_ch.ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign res         = res_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    g_nxt     = g_r;
    n_nxt     = n_r;
    clr_nxt   = clr_r;
    cur_nxt   = cur_r;
    aux_nxt   = aux_r;
    need_nxt  = need_r;
    split_nxt = split_r;
    res_nxt   = res_r;
    ram_req   = '{we: 1'b0, addr: g_r, wdata: ffba_pkg::HDR_ZERO};

    unique case (state_r)
      S_CLR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = clr_r;
        ram_req.wdata = (clr_r == '0) ? ffba_pkg::HDR_INIT : ffba_pkg::HDR_ZERO;
        clr_nxt       = clr_r + IDX_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          res_nxt = '0;
          g_nxt   = '0;
          unique case (in_ch.func)
            ffba_pkg::FUNC_ALLOC: begin
              need_nxt = req_round[ffba_pkg::REQ_W:ffba_pkg::GRAN_SHIFT];
              if (in_ch.request_bytes == '0) begin
                res_nxt.status = ffba_pkg::STATUS_ZERO;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_A_RD;
              end
            end
            ffba_pkg::FUNC_FREE: begin
              if (in_ch.block_offset != '0 &&
                  in_ch.block_offset[ffba_pkg::GRAN_SHIFT-1:0] == '0) begin
                g_nxt     = in_ch.block_offset[ffba_pkg::OFF_W-1:ffba_pkg::GRAN_SHIFT]
                            - IDX_W'(1);
                state_nxt = S_F_RD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            ffba_pkg::FUNC_STATS: state_nxt = S_S_RD;
            default:              state_nxt = S_DONE;
          endcase
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      // Allocate: first-fit walk
      S_A_RD: begin
        ram_req.addr = g_r;
        state_nxt    = S_A_CHK;
      end

      S_A_CHK: begin
        if (fits) begin
          cur_nxt   = ram_rdata;
          split_nxt = ({1'b0, need_r} < (ffba_pkg::NEED_W + 1)'(blk_size));
          n_nxt     = g_r + IDX_W'(1) + need_r[IDX_W-1:0];
          res_nxt.data_offset = {g_r + IDX_W'(1), {ffba_pkg::GRAN_SHIFT{1'b0}}};
          state_nxt = split_nxt ? S_A_WN : S_A_WG;
        end else if (ram_rdata.nx_ok) begin
          g_nxt     = ram_rdata.nx;
          state_nxt = S_A_RD;
        end else begin
          res_nxt.status = ffba_pkg::STATUS_NOFIT;
          state_nxt      = S_DONE;
        end
      end

      S_A_WN: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = n_r;
        ram_req.wdata = '{valid: 1'b1, free: 1'b1, nx_ok: cur_r.nx_ok, nx: cur_r.nx,
                          pv_ok: 1'b1, pv: g_r};
        state_nxt     = cur_r.nx_ok ? S_A_PRD : S_A_WG;
      end

      S_A_PRD: begin
        ram_req.addr = cur_r.nx;
        state_nxt    = S_A_PWR;
      end

      S_A_PWR: begin
        ram_req.we       = 1'b1;
        ram_req.addr     = cur_r.nx;
        ram_req.wdata    = ram_rdata;
        ram_req.wdata.pv = n_r;
        state_nxt        = S_A_WG;
      end

      S_A_WG: begin
        ram_req.we         = 1'b1;
        ram_req.addr       = g_r;
        ram_req.wdata      = cur_r;
        ram_req.wdata.free = 1'b0;
        if (split_r) begin
          ram_req.wdata.nx_ok = 1'b1;
          ram_req.wdata.nx    = n_r;
        end
        state_nxt = S_DONE;
      end

      // Free: mark, merge with next, then with previous
      S_F_RD: begin
        ram_req.addr = g_r;
        state_nxt    = S_F_CHK;
      end

      S_F_CHK: begin
        if (!ram_rdata.valid) begin
          state_nxt = S_DONE;
        end else begin
          cur_nxt      = ram_rdata;
          cur_nxt.free = 1'b1;
          state_nxt    = ram_rdata.nx_ok ? S_F_NRD : S_F_PV;
        end
      end

      S_F_NRD: begin
        ram_req.addr = cur_r.nx;
        n_nxt        = cur_r.nx;
        state_nxt    = S_F_NCHK;
      end

      S_F_NCHK: begin
        if (ram_rdata.valid && ram_rdata.free) begin
          cur_nxt.nx_ok = ram_rdata.nx_ok;
          cur_nxt.nx    = ram_rdata.nx;
          state_nxt     = S_F_NCLR;
        end else begin
          state_nxt = S_F_PV;
        end
      end

      S_F_NCLR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = n_r;
        ram_req.wdata = ffba_pkg::HDR_ZERO;
        state_nxt     = cur_r.nx_ok ? S_F_NPRD : S_F_PV;
      end

      S_F_NPRD: begin
        ram_req.addr = cur_r.nx;
        state_nxt    = S_F_NPWR;
      end

      S_F_NPWR: begin
        ram_req.we       = 1'b1;
        ram_req.addr     = cur_r.nx;
        ram_req.wdata    = ram_rdata;
        ram_req.wdata.pv = g_r;
        state_nxt        = S_F_PV;
      end

      S_F_PV: begin
        state_nxt = cur_r.pv_ok ? S_F_LRD : S_F_WG;
      end

      S_F_LRD: begin
        ram_req.addr = cur_r.pv;
        state_nxt    = S_F_LCHK;
      end

      S_F_LCHK: begin
        if (ram_rdata.valid && ram_rdata.free) begin
          aux_nxt       = ram_rdata;
          aux_nxt.nx_ok = cur_r.nx_ok;
          aux_nxt.nx    = cur_r.nx;
          state_nxt     = S_F_GCLR;
        end else begin
          state_nxt = S_F_WG;
        end
      end

      S_F_GCLR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = g_r;
        ram_req.wdata = ffba_pkg::HDR_ZERO;
        state_nxt     = aux_r.nx_ok ? S_F_LPRD : S_F_LWR;
      end

      S_F_LPRD: begin
        ram_req.addr = aux_r.nx;
        state_nxt    = S_F_LPWR;
      end

      S_F_LPWR: begin
        ram_req.we       = 1'b1;
        ram_req.addr     = aux_r.nx;
        ram_req.wdata    = ram_rdata;
        ram_req.wdata.pv = cur_r.pv;
        state_nxt        = S_F_LWR;
      end

      S_F_LWR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = cur_r.pv;
        ram_req.wdata = aux_r;
        state_nxt     = S_DONE;
      end

      S_F_WG: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = g_r;
        ram_req.wdata = cur_r;
        state_nxt     = S_DONE;
      end

      // Statistics walk: read one header, accumulate the next cycle
      S_S_RD: begin
        ram_req.addr = g_r;
        state_nxt    = S_S_RD;
        split_nxt    = 1'b1;
        if (split_r) begin
          res_nxt.total_blocks = res_r.total_blocks + ffba_pkg::CNT_W'(1);
          if (ram_rdata.free) begin
            res_nxt.free_blocks = res_r.free_blocks + ffba_pkg::CNT_W'(1);
            res_nxt.free_bytes  = res_r.free_bytes
                                  + ffba_pkg::BYTES_W'({blk_size, {ffba_pkg::GRAN_SHIFT{1'b0}}});
          end else begin
            res_nxt.used_bytes  = res_r.used_bytes
                                  + ffba_pkg::BYTES_W'({blk_size, {ffba_pkg::GRAN_SHIFT{1'b0}}});
          end
          split_nxt = 1'b0;
          if (ram_rdata.nx_ok) begin
            g_nxt = ram_rdata.nx;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      split_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      split_r <= (state_r == S_IDLE) ? 1'b0 : split_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    g_r    <= g_nxt;
    n_r    <= n_nxt;
    cur_r  <= cur_nxt;
    aux_r  <= aux_nxt;
    need_r <= need_nxt;
    res_r  <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_block_allocator_unit.sv =====
// First-fit block allocator top level: header RAM, sequencer, result register.
//
// Manages a 64 KiB heap in 16-byte granules as an address-ordered chain of block
// headers held in a 4096-entry single-port RAM. After reset the block runs a
// clearing pass over all 4096 headers with in_ch.ready low. Each transaction then
// takes the request, works through the single header RAM port and hands over the
// result. Allocate reads and tests each block in the first-fit walk, then updates
// the block it takes, and when it splits off a remainder also writes the remainder
// header and the next block's back link; statistics reads every block in the
// chain; free marks the block and merges it with a free next, then previous, block.
// One transaction is in work at a time; a finished result sits in the output
// register while the next request is taken.
`default_nettype none
module first_fit_block_allocator_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  ffba_in_if.sink   in_ch,
  ffba_out_if.source out_ch
);

  ffba_pkg::ram_req_t ram_req;
  ffba_pkg::hdr_t     ram_rdata;
  logic [ffba_pkg::HDR_W-1:0] ram_rbits;
  logic               res_valid;
  logic               res_ready;
  ffba_pkg::res_t     res;
  logic               out_valid_r;
  ffba_pkg::res_t     out_r;

  ffba_ram #(
    .WIDTH (ffba_pkg::HDR_W),
    .DEPTH (ffba_pkg::NUM_GRAN)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rbits)
  );

  assign ram_rdata = ffba_pkg::hdr_t'(ram_rbits);

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_offset  = out_r.data_offset;
  assign out_ch.status       = out_r.status;
  assign out_ch.total_blocks = out_r.total_blocks;
  assign out_ch.free_blocks  = out_r.free_blocks;
  assign out_ch.used_bytes   = out_r.used_bytes;
  assign out_ch.free_bytes   = out_r.free_bytes;

`ifndef SYNTHESIS
  a_no_accept_while_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ch.ready)
    else $error("request taken while a result is pending");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> !in_ch.ready)
    else $error("header write while idle");

  a_nofit_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ffba_pkg::STATUS_NOFIT) |-> out_ch.data_offset == '0)
    else $error("failed allocate returned an offset");
`endif

endmodule
`default_nettype wire
